// ===== design/p2drr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2drr_pkg
// Shared types, widths and constants of the planar pose residual pipeline.
// ----------------------------------------------------------------------------
package p2drr_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int NUM_ITER      = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

  localparam int UNIT_SHIFT  = 30;
  localparam int PHASE_SHIFT = UNIT_SHIFT + FRAC_BITS;

  localparam logic [63:0] TURN_CONST = 64'd733972625820500304;
  localparam logic [31:0] TURN_LO    = TURN_CONST[31:0];
  localparam logic [31:0] TURN_HI    = TURN_CONST[63:32];

  localparam int XY_W  = 34;
  localparam int Z_W   = 34;
  localparam int C_W   = 32;
  localparam int D_W   = 33;
  localparam int P_W   = C_W + D_W;
  localparam int S_W   = P_W + 1;
  localparam int R_W   = S_W - UNIT_SHIFT;
  localparam int SAT_W = 40;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [XY_W-1:0] ONE_Q30     = XY_W'(1073741824);

  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MEASURED_DX     = 2'd0,
    REG_MEASURED_DY     = 2'd1,
    REG_MEASURED_DTHETA = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dh;
  } side_t;

  typedef struct packed {
    quad_t quad;
    side_t side;
  } carry_t;

  typedef struct packed {
    logic signed [31:0] mdx;
    logic signed [31:0] mdy;
    logic signed [31:0] mdth;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] rh;
    logic signed [31:0] ry;
    logic signed [31:0] rx;
  } res_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [29:0] atan_turn(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/p2drr_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2drr_phase
// Position differences and heading-to-phase conversion: four stages that
// scale the heading to 2^32 per turn and split it into quadrant and residue.
// ----------------------------------------------------------------------------
module p2drr_phase (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [31:0]                ax,
  input  logic signed [31:0]                ay,
  input  logic signed [31:0]                ah,
  input  logic signed [31:0]                bx,
  input  logic signed [31:0]                by,
  input  logic signed [31:0]                bh,
  output logic                              out_valid,
  output p2drr_pkg::carry_t                 out_carry,
  output logic signed [p2drr_pkg::Z_W-1:0]  out_z
);

  localparam int SHIFT = p2drr_pkg::PHASE_SHIFT;
  localparam int ZW    = p2drr_pkg::Z_W;
  localparam logic [31:0] QOFF = 32'h2000_0000;
  localparam logic signed [ZW-1:0] ZHALF = ZW'(32'h2000_0000);

  logic                v1, v2, v3;
  logic                neg1, neg2, neg3;
  logic [31:0]         mag1;
  logic [63:0]         prod_lo2, prod_hi2;
  logic [31:0]         p3;
  p2drr_pkg::side_t    side1, side2, side3;
  logic [95:0]         full;
  logic [31:0]         u;

  assign full = {prod_hi2, 32'd0} + {32'd0, prod_lo2};
  assign u    = neg3 ? (QOFF - p3) : (p3 + QOFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    if (en) begin
      neg1     <= ah[31];
      mag1     <= ah[31] ? (32'd0 - ah) : ah;
      side1.dx <= {bx[31], bx} - {ax[31], ax};
      side1.dy <= {by[31], by} - {ay[31], ay};
      side1.dh <= {bh[31], bh} - {ah[31], ah};

      neg2     <= neg1;
      prod_lo2 <= mag1 * p2drr_pkg::TURN_LO;
      prod_hi2 <= mag1 * p2drr_pkg::TURN_HI;
      side2    <= side1;

      neg3     <= neg2;
      p3       <= full[SHIFT+31:SHIFT];
      side3    <= side2;

      out_carry.quad <= p2drr_pkg::quad_t'(u[31:30]);
      out_carry.side <= side3;
      out_z          <= $signed({{(ZW-30){1'b0}}, u[29:0]}) - ZHALF;
    end
  end

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_z >= -ZHALF && out_z < ZHALF))
    else $error("phase residue out of range");

endmodule

// ===== design/p2drr_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2drr_cordic
// Unrolled rotation-mode CORDIC, one registered stage per iteration.
// ----------------------------------------------------------------------------
module p2drr_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  p2drr_pkg::carry_t                  in_carry,
  input  logic signed [p2drr_pkg::Z_W-1:0]   in_z,
  output logic                               out_valid,
  output p2drr_pkg::carry_t                  out_carry,
  output logic signed [p2drr_pkg::XY_W-1:0]  out_x,
  output logic signed [p2drr_pkg::XY_W-1:0]  out_y
);

  localparam int N  = p2drr_pkg::NUM_ITER;
  localparam int XW = p2drr_pkg::XY_W;
  localparam int ZW = p2drr_pkg::Z_W;

  logic                 vr [N];
  logic signed [XW-1:0] xr [N];
  logic signed [XW-1:0] yr [N];
  logic signed [ZW-1:0] zr [N];
  p2drr_pkg::carry_t    cr [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'(p2drr_pkg::atan_turn(i));
    logic                 vi;
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    p2drr_pkg::carry_t    ci;

    if (i == 0) begin : g_head
      assign vi = in_valid;
      assign xi = p2drr_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = in_z;
      assign ci = in_carry;
    end else begin : g_tail
      assign vi = vr[i-1];
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign ci = cr[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else if (en) begin
        vr[i] <= vi;
      end
      if (en) begin
        cr[i] <= ci;
        if (zi >= 0) begin
          xr[i] <= xi - (yi >>> i);
          yr[i] <= yi + (xi >>> i);
          zr[i] <= zi - ANG;
        end else begin
          xr[i] <= xi + (yi >>> i);
          yr[i] <= yi - (xi >>> i);
          zr[i] <= zi + ANG;
        end
      end
    end
  end

  assign out_valid = vr[N-1];
  assign out_carry = cr[N-1];
  assign out_x     = xr[N-1];
  assign out_y     = yr[N-1];

endmodule

// ===== design/p2drr_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2drr_rotate
// Quadrant fold and clamp, rotation products, rounding shift, and the
// subtraction of the measured pose with saturation: four stages.
// ----------------------------------------------------------------------------
module p2drr_rotate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  p2drr_pkg::carry_t                  in_carry,
  input  logic signed [p2drr_pkg::XY_W-1:0]  in_x,
  input  logic signed [p2drr_pkg::XY_W-1:0]  in_y,
  input  p2drr_pkg::meas_t                   meas,
  output logic                               out_valid,
  output p2drr_pkg::res_t                    out_res
);

  localparam int XW   = p2drr_pkg::XY_W;
  localparam int CW   = p2drr_pkg::C_W;
  localparam int DW   = p2drr_pkg::D_W;
  localparam int PW   = p2drr_pkg::P_W;
  localparam int SW   = p2drr_pkg::S_W;
  localparam int RW   = p2drr_pkg::R_W;
  localparam int SATW = p2drr_pkg::SAT_W;
  localparam int US   = p2drr_pkg::UNIT_SHIFT;
  localparam logic signed [CW-1:0] ONE_C = CW'(p2drr_pkg::ONE_Q30);
  localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (US - 1);
  localparam logic signed [SATW-1:0] SAT_MAX = SATW'(32'sh7FFF_FFFF);
  localparam logic signed [SATW-1:0] SAT_MIN = SATW'(32'sh8000_0000);

  function automatic logic signed [CW-1:0] clamp_unit(input logic signed [XW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > p2drr_pkg::ONE_Q30) begin
      r = ONE_C;
    end else if (v < -p2drr_pkg::ONE_Q30) begin
      r = -ONE_C;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic                  v1, v2, v3;
  logic signed [XW-1:0]  cm, sm;
  logic signed [CW-1:0]  c1, s1;
  p2drr_pkg::side_t      side1;
  logic signed [PW-1:0]  cdx2, sdy2, cdy2, sdx2;
  logic signed [DW-1:0]  dh2, dh3;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic signed [RW-1:0]  rx3, ry3;

  always_comb begin
    case (in_carry.quad)
      p2drr_pkg::QUAD_0: begin
        cm = in_x;
        sm = in_y;
      end
      p2drr_pkg::QUAD_1: begin
        cm = -in_y;
        sm = in_x;
      end
      p2drr_pkg::QUAD_2: begin
        cm = -in_x;
        sm = -in_y;
      end
      default: begin
        cm = in_y;
        sm = -in_x;
      end
    endcase
  end

  assign sum_x = SW'(cdx2) + SW'(sdy2) + ROUND;
  assign sum_y = SW'(cdy2) - SW'(sdx2) + ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    if (en) begin
      c1    <= clamp_unit(cm);
      s1    <= clamp_unit(sm);
      side1 <= in_carry.side;

      cdx2  <= c1 * side1.dx;
      sdy2  <= s1 * side1.dy;
      cdy2  <= c1 * side1.dy;
      sdx2  <= s1 * side1.dx;
      dh2   <= side1.dh;

      rx3   <= sum_x[SW-1:US];
      ry3   <= sum_y[SW-1:US];
      dh3   <= dh2;

      out_res.rx <= sat32(SATW'(rx3) - SATW'(meas.mdx));
      out_res.ry <= sat32(SATW'(ry3) - SATW'(meas.mdy));
      out_res.rh <= sat32(SATW'(dh3) - SATW'(meas.mdth));
    end
  end

  a_unit_clamp: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (c1 <= ONE_C && c1 >= -ONE_C && s1 <= ONE_C && s1 >= -ONE_C))
    else $error("sine or cosine beyond unit range");

endmodule

// ===== design/p2drr_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2drr_skid
// Output register with one skid entry; ready toward the pipeline is
// registered and drops only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module p2drr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  p2drr_pkg::res_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output p2drr_pkg::res_t  out_data
);

  logic            skid_valid;
  p2drr_pkg::res_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid entry dropped while output stalled");

  a_skid_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_valid && !out_ready) |=> skid_valid)
    else $error("transaction lost on output stall");

endmodule

// ===== design/pose2d_relative_residual.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose2d_relative_residual
// Residual of one planar pose-graph edge: rotate (b - a) into a's frame,
// subtract the measured offset and heading change, saturate to Q16.16.
//
//   Channel   Dir  Width  Contents
//   s_axis    in   192    poses a and b
//   m_axis    out   96    residual x, y, heading
//   cfg       in     32   measured dx, dy, dtheta (write only)
//
// One transaction per cycle in steady state while m_axis keeps accepting.
// Data passes through 4 phase stages, 18 CORDIC stages, 4 rotation
// stages and the output register.
// rst clears all valid bits and the measured-pose registers.
// A stalled m_axis fills the skid entry; s_axis_tready then drops and the
// whole pipeline holds until the entry drains.
// ----------------------------------------------------------------------------
module pose2d_relative_residual (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pose_a_x, pose_a_y, pose_a_heading, pose_b_x, pose_b_y, pose_b_heading
  input  logic [191:0]                         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // resid_x, resid_y, resid_heading
  output logic [95:0]                          m_axis_tdata,
  input  logic                                 cfg_write,
  input  logic [p2drr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [31:0]                          cfg_wdata
);

  p2drr_pkg::meas_t   meas;
  logic               en;

  logic               ph_valid;
  p2drr_pkg::carry_t  ph_carry;
  logic signed [p2drr_pkg::Z_W-1:0]  ph_z;

  logic               cd_valid;
  p2drr_pkg::carry_t  cd_carry;
  logic signed [p2drr_pkg::XY_W-1:0] cd_x, cd_y;

  logic               rt_valid;
  p2drr_pkg::res_t    rt_res;
  p2drr_pkg::res_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas <= '0;
    end else if (cfg_write) begin
      case (cfg_addr)
        p2drr_pkg::REG_MEASURED_DX:     meas.mdx  <= cfg_wdata;
        p2drr_pkg::REG_MEASURED_DY:     meas.mdy  <= cfg_wdata;
        p2drr_pkg::REG_MEASURED_DTHETA: meas.mdth <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = en;

  p2drr_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .ax        (s_axis_tdata[31:0]),
    .ay        (s_axis_tdata[63:32]),
    .ah        (s_axis_tdata[95:64]),
    .bx        (s_axis_tdata[127:96]),
    .by        (s_axis_tdata[159:128]),
    .bh        (s_axis_tdata[191:160]),
    .out_valid (ph_valid),
    .out_carry (ph_carry),
    .out_z     (ph_z)
  );

  p2drr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ph_valid),
    .in_carry  (ph_carry),
    .in_z      (ph_z),
    .out_valid (cd_valid),
    .out_carry (cd_carry),
    .out_x     (cd_x),
    .out_y     (cd_y)
  );

  p2drr_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cd_valid),
    .in_carry  (cd_carry),
    .in_x      (cd_x),
    .in_y      (cd_y),
    .meas      (meas),
    .out_valid (rt_valid),
    .out_res   (rt_res)
  );

  p2drr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .in_ready  (en),
    .in_data   (rt_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

// ===== tb/pose2d_relative_residual_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose2d_relative_residual_tb
// Streams pairs of planar poses through the pose-graph edge residual block.
// Each accepted pose pair is run through an in-bench fixed-point model
// (heading phase reduction, CORDIC, rotation into a's frame, saturation)
// and the residual is compared field by field with the block's output.
// Covers field extremes, quadrant and saturation corners, register settings
// including the extremes and an unmapped index, random traffic under
// several idle/stall mixes, and a long output hold-off that fills the
// pipeline.
// ----------------------------------------------------------------------------
module pose2d_relative_residual_tb;

  localparam int           FRAC_Q      = p2drr_pkg::FRAC_BITS;
  localparam int           ITERATIONS  = p2drr_pkg::NUM_ITER;
  localparam logic [63:0]  TURN_SCALE  = 64'd733972625820500304;
  localparam longint       GAIN_Q30    = 652032874;
  localparam longint       UNIT_Q30    = 1073741824;
  localparam longint       HALF_OCTANT = 536870912;
  localparam int           DRAIN_WAIT  = 40;
  localparam int           HOLD_CYCLES = 300;
  localparam logic [p2drr_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] PI_Q    = 32'sd205887;
  localparam logic signed [31:0] HALF_PI = 32'sd102944;

  // a_x, a_y, a_heading, b_x, b_y, b_heading from the lowest bit up
  typedef struct packed {
    logic signed [31:0] b_heading;
    logic signed [31:0] b_y;
    logic signed [31:0] b_x;
    logic signed [31:0] a_heading;
    logic signed [31:0] a_y;
    logic signed [31:0] a_x;
  } pose_pair_t;

  // x, y, heading from the lowest bit up
  typedef struct packed {
    logic signed [31:0] heading;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } residual_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pose_a_x, pose_a_y, pose_a_heading, pose_b_x, pose_b_y, pose_b_heading
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // resid_x, resid_y, resid_heading
  logic [95:0]  m_axis_tdata;
  logic         cfg_write = 1'b0;
  logic [p2drr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  longint arctan_turn [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic signed [31:0] meas_dx = '0;
  logic signed [31:0] meas_dy = '0;
  logic signed [31:0] meas_dth = '0;

  residual_t residual_q [$];
  int        fault_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  logic      hold_off = 1'b0;

  pose2d_relative_residual dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_write     (cfg_write),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [31:0] saturate32(input logic signed [79:0] v);
    if (v > 80'sh7FFF_FFFF) begin
      return S32_MAX;
    end
    if (v < -80'sh8000_0000) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q30) begin
      return UNIT_Q30;
    end
    if (v < -UNIT_Q30) begin
      return -UNIT_Q30;
    end
    return v;
  endfunction

  function automatic residual_t predict_residual(input pose_pair_t p);
    logic [63:0]        mag;
    logic [127:0]       prod;
    logic [31:0]        phase;
    logic [31:0]        u;
    logic [1:0]         quad;
    longint             x, y, z, xs, ys, cs, sn;
    logic signed [79:0] c, s, dx, dy, acc_x, acc_y, dh;
    residual_t          r;
    mag = p.a_heading[31] ? 64'(-longint'(p.a_heading)) : 64'(longint'(p.a_heading));
    prod = 128'(mag) * 128'(TURN_SCALE);
    phase = 32'(prod >> (30 + FRAC_Q));
    if (p.a_heading[31]) begin
      phase = 32'd0 - phase;
    end
    u = phase + 32'h2000_0000;
    quad = u[31:30];
    z = longint'(u[29:0]) - HALF_OCTANT;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_turn[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_turn[i];
      end
    end
    case (quad)
      p2drr_pkg::QUAD_0: begin
        cs = x;
        sn = y;
      end
      p2drr_pkg::QUAD_1: begin
        cs = -y;
        sn = x;
      end
      p2drr_pkg::QUAD_2: begin
        cs = -x;
        sn = -y;
      end
      default: begin
        cs = y;
        sn = -x;
      end
    endcase
    c = 80'(clamp_unit(cs));
    s = 80'(clamp_unit(sn));
    dx = 80'(longint'(p.b_x) - longint'(p.a_x));
    dy = 80'(longint'(p.b_y) - longint'(p.a_y));
    acc_x = c * dx + s * dy + 80'sd536870912;
    acc_y = c * dy - s * dx + 80'sd536870912;
    dh = 80'(longint'(p.b_heading) - longint'(p.a_heading) - longint'(meas_dth));
    r.x = saturate32((acc_x >>> 30) - meas_dx);
    r.y = saturate32((acc_y >>> 30) - meas_dy);
    r.heading = saturate32(dh);
    return r;
  endfunction

  function automatic pose_pair_t mk_pose(input logic signed [31:0] ax, ay, ah, bx, by, bh);
    pose_pair_t p;
    p.a_x = ax;
    p.a_y = ay;
    p.a_heading = ah;
    p.b_x = bx;
    p.b_y = by;
    p.b_heading = bh;
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return int'($urandom_range(2097152)) - 1048576;
      8: begin
        case ($urandom_range(3))
          0: return S32_MAX;
          1: return S32_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return S32_MAX - int'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_heading();
    case ($urandom_range(4))
      0: return $urandom;
      default: return int'($urandom_range(1647100)) - 823550;
    endcase
  endfunction

  function automatic pose_pair_t rand_pose();
    return mk_pose(rand_coord(), rand_coord(), rand_heading(),
                   rand_coord(), rand_coord(), rand_heading());
  endfunction

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    m_axis_tready <= !hold_off && (int'($urandom_range(99)) >= stall_pct);
  end

  always @(posedge clk) begin
    residual_t got;
    residual_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (residual_q.size() == 0) begin
        if (fault_count < 10) begin
          $display("unexpected residual x=%0d y=%0d h=%0d", got.x, got.y, got.heading);
        end
        fault_count++;
      end else begin
        want = residual_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading) begin
          if (fault_count < 10) begin
            $display("residual differs: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                     want.x, want.y, want.heading, got.x, got.y, got.heading);
          end
          fault_count++;
        end
      end
    end
  end

  task automatic send_pose(input pose_pair_t p);
    while (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    residual_q.push_back(predict_residual(p));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (residual_q.size() != 0);
  endtask

  task automatic write_reg(input logic [p2drr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      p2drr_pkg::REG_MEASURED_DX:     meas_dx = val;
      p2drr_pkg::REG_MEASURED_DY:     meas_dy = val;
      p2drr_pkg::REG_MEASURED_DTHETA: meas_dth = val;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_measurement(input logic [31:0] mdx, mdy, mdth);
    write_reg(p2drr_pkg::REG_MEASURED_DX, mdx);
    write_reg(p2drr_pkg::REG_MEASURED_DY, mdy);
    write_reg(p2drr_pkg::REG_MEASURED_DTHETA, mdth);
  endtask

  task automatic test_corner_poses();
    send_pose(mk_pose(0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(0, 0, 0, Q_ONE, 2 * Q_ONE, Q_ONE));
    send_pose(mk_pose(Q_ONE, -Q_ONE, HALF_PI, 3 * Q_ONE, Q_ONE, PI_Q));
    send_pose(mk_pose(-Q_ONE, Q_ONE, PI_Q, Q_ONE, 2 * Q_ONE, 0));
    send_pose(mk_pose(0, 0, -HALF_PI, Q_ONE, Q_ONE, -PI_Q));
    send_pose(mk_pose(0, 0, -PI_Q, 5 * Q_ONE, -3 * Q_ONE, 0));
    send_pose(mk_pose(0, 0, HALF_PI / 2, Q_ONE, 0, 0));
    send_pose(mk_pose(0, 0, S32_MAX, Q_ONE, Q_ONE, 0));
    send_pose(mk_pose(0, 0, S32_MIN, Q_ONE, -Q_ONE, 0));
    send_pose(mk_pose(S32_MIN, 0, 0, S32_MAX, 0, 0));
    send_pose(mk_pose(S32_MAX, 0, 0, S32_MIN, 0, 0));
    send_pose(mk_pose(0, S32_MIN, 0, 0, S32_MAX, 0));
    send_pose(mk_pose(0, 0, S32_MIN, 0, 0, S32_MAX));
    send_pose(mk_pose(0, 0, S32_MAX, 0, 0, S32_MIN));
    send_pose(mk_pose(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    send_pose(mk_pose(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
    send_pose(mk_pose(-1, -1, -1, -1, -1, -1));
    settle();
  endtask

  task automatic test_register_extremes();
    set_measurement(S32_MAX, S32_MIN, S32_MAX);
    send_pose(mk_pose(0, 0, 0, S32_MIN, S32_MAX, S32_MIN));
    send_pose(mk_pose(Q_ONE, Q_ONE, HALF_PI, 2 * Q_ONE, 0, PI_Q));
    settle();
    set_measurement(S32_MIN, S32_MAX, S32_MIN);
    send_pose(mk_pose(0, 0, 0, S32_MAX, S32_MIN, S32_MAX));
    send_pose(mk_pose(Q_ONE, Q_ONE, -HALF_PI, 2 * Q_ONE, 0, -PI_Q));
    settle();
    set_measurement(Q_ONE, -Q_ONE / 2, HALF_PI);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_pose(mk_pose(0, 0, HALF_PI, Q_ONE, 2 * Q_ONE, PI_Q));
    settle();
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int count);
    set_measurement(rand_coord(), rand_coord(), rand_heading());
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count) begin
      send_pose(rand_pose());
    end
    settle();
  endtask

  task automatic test_output_holdoff();
    idle_pct = 0;
    stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (60) begin
      send_pose(rand_pose());
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_poses();
    test_register_extremes();
    test_random_stream(0, 0, 100);
    test_random_stream(83, 0, 100);
    test_random_stream(0, 83, 100);
    test_random_stream(9, 9, 100);
    test_output_holdoff();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0 && residual_q.size() == 0) begin
      $display("pose2d_relative_residual: match");
    end else begin
      $display("pose2d_relative_residual: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("pose2d_relative_residual: mismatch");
    $finish;
  end

endmodule
